>>> rtl/sml_pkg.sv
// ----------------------------------------------------------------------------
// sml_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// sorted list merge block.
// ----------------------------------------------------------------------------
package sml_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int BUF_DEPTH  = 2 * LIST_DEPTH;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int IDX_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int BUF_IDX_W = $clog2(BUF_DEPTH);
  localparam int TOT_W     = $clog2(BUF_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN         = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load_first;
    logic load_second;
    logic run_start;
    logic fetch;
    logic merge_step;
    logic emit_step;
    logic clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic total_zero;
    logic slot_last;
    logic emit_last;
  } status_t;

endpackage

>>> rtl/sml_ram.sv
// ----------------------------------------------------------------------------
// sml_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sml_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sml_ctrl.sv
// ----------------------------------------------------------------------------
// sml_ctrl
// Sequencer for the merge: accepts loads and runs, steps the back-to-front
// merge (fetch, then compare/write) and the front-to-back emit.
// ----------------------------------------------------------------------------
module sml_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [sml_pkg::OP_W-1:0] in_op,
  input  sml_pkg::status_t         status,
  output sml_pkg::cmd_t            cmd,
  output logic                     busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_op)
            sml_pkg::OP_LOAD_FIRST:  cmd.load_first  = 1'b1;
            sml_pkg::OP_LOAD_SECOND: cmd.load_second = 1'b1;
            sml_pkg::OP_RUN: begin
              cmd.run_start = 1'b1;
              if (status.total_zero) begin
                cmd.clear = 1'b1;
              end else begin
                state_nxt = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.merge_step = 1'b1;
        state_nxt = status.slot_last ? ST_EMIT : ST_FETCH;
      end
      ST_EMIT: begin
        cmd.emit_step = 1'b1;
        if (status.emit_last) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> rtl/sml_dp.sv
// ----------------------------------------------------------------------------
// sml_dp
// Datapath: list memories with fill counts, merge comparator, merge buffer
// and the result register stage.
// ----------------------------------------------------------------------------
module sml_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sml_pkg::cmd_t                     cmd,
  input  logic signed [sml_pkg::DATA_W-1:0] in_value,
  output sml_pkg::status_t                  status,
  output logic                              out_valid,
  output logic signed [sml_pkg::DATA_W-1:0] out_merged_value,
  output logic                              out_last,
  output logic                              out_overflow
);

  localparam logic [sml_pkg::CNT_W-1:0] CNT_FULL = sml_pkg::CNT_W'(sml_pkg::LIST_DEPTH);

  logic [sml_pkg::CNT_W-1:0]     first_cnt_r, second_cnt_r;
  logic [sml_pkg::CNT_W-1:0]     left_first_r, left_second_r;
  logic [sml_pkg::TOT_W-1:0]     slot_r, total_r;
  logic [sml_pkg::BUF_IDX_W-1:0] emit_idx_r;
  logic                          dropped_r;
  logic                          out_valid_r, out_last_r, out_ovf_r;

  logic [sml_pkg::TOT_W-1:0]     count_sum;
  logic [sml_pkg::TOT_W-1:0]     slot_m1;
  logic [sml_pkg::TOT_W-1:0]     emit_next;
  logic [sml_pkg::CNT_W-1:0]     left_first_m1, left_second_m1;
  logic [sml_pkg::DATA_W-1:0]    first_q, second_q, buf_q, buf_wdata;
  logic                          first_we, second_we, take_second;

  assign count_sum      = sml_pkg::TOT_W'(first_cnt_r) + sml_pkg::TOT_W'(second_cnt_r);
  assign slot_m1        = slot_r - 1'b1;
  assign emit_next      = sml_pkg::TOT_W'(emit_idx_r) + 1'b1;
  assign left_first_m1  = left_first_r - 1'b1;
  assign left_second_m1 = left_second_r - 1'b1;

  assign first_we  = cmd.load_first  && (first_cnt_r  != CNT_FULL);
  assign second_we = cmd.load_second && (second_cnt_r != CNT_FULL);

  // back-to-front fill: larger tail goes to the highest open slot, second wins ties
  always_comb begin
    if (left_first_r == '0) begin
      take_second = 1'b1;
    end else if (left_second_r == '0) begin
      take_second = 1'b0;
    end else begin
      take_second = ($signed(first_q) <= $signed(second_q));
    end
    buf_wdata = take_second ? second_q : first_q;
  end

  sml_ram #(.WIDTH(sml_pkg::DATA_W), .DEPTH(sml_pkg::LIST_DEPTH)) u_first_ram (
    .clk   (clk),
    .we    (first_we),
    .waddr (first_cnt_r[sml_pkg::IDX_W-1:0]),
    .wdata (in_value),
    .re    (cmd.fetch),
    .raddr (left_first_m1[sml_pkg::IDX_W-1:0]),
    .rdata (first_q)
  );

  sml_ram #(.WIDTH(sml_pkg::DATA_W), .DEPTH(sml_pkg::LIST_DEPTH)) u_second_ram (
    .clk   (clk),
    .we    (second_we),
    .waddr (second_cnt_r[sml_pkg::IDX_W-1:0]),
    .wdata (in_value),
    .re    (cmd.fetch),
    .raddr (left_second_m1[sml_pkg::IDX_W-1:0]),
    .rdata (second_q)
  );

  sml_ram #(.WIDTH(sml_pkg::DATA_W), .DEPTH(sml_pkg::BUF_DEPTH)) u_buf_ram (
    .clk   (clk),
    .we    (cmd.merge_step),
    .waddr (slot_m1[sml_pkg::BUF_IDX_W-1:0]),
    .wdata (buf_wdata),
    .re    (cmd.emit_step),
    .raddr (emit_idx_r),
    .rdata (buf_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      dropped_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_step;
      if (first_we) begin
        first_cnt_r <= first_cnt_r + 1'b1;
      end
      if (second_we) begin
        second_cnt_r <= second_cnt_r + 1'b1;
      end
      if ((cmd.load_first && !first_we) || (cmd.load_second && !second_we)) begin
        dropped_r <= 1'b1;
      end
      if (cmd.clear) begin
        first_cnt_r  <= '0;
        second_cnt_r <= '0;
        dropped_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      left_first_r  <= first_cnt_r;
      left_second_r <= second_cnt_r;
      slot_r        <= count_sum;
      total_r       <= count_sum;
      emit_idx_r    <= '0;
    end
    if (cmd.merge_step) begin
      slot_r <= slot_m1;
      if (take_second) begin
        left_second_r <= left_second_m1;
      end else begin
        left_first_r <= left_first_m1;
      end
    end
    if (cmd.emit_step) begin
      emit_idx_r <= emit_idx_r + 1'b1;
      out_last_r <= (emit_next == total_r);
      out_ovf_r  <= dropped_r;
    end
  end

  assign status.total_zero = (count_sum == '0);
  assign status.slot_last  = (slot_r == sml_pkg::TOT_W'(1));
  assign status.emit_last  = (emit_next == total_r);

  assign out_valid        = out_valid_r;
  assign out_merged_value = $signed(buf_q);
  assign out_last         = out_last_r;
  assign out_overflow     = out_ovf_r;

endmodule

>>> rtl/sorted_list_merge.sv
// ----------------------------------------------------------------------------
// sorted_list_merge
// Merges two ascending lists of signed 32-bit values, first list wins ties.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken on a rising edge with start high and
//   busy low. in_op selects load into the first list, load into the second
//   list, or run. Each list holds LIST_DEPTH entries; a load into a full list
//   is dropped and flagged through out_overflow on the next run's results.
//   A load does not raise busy, so loads may be issued every cycle.
//   A run over N = m + n stored elements keeps busy high while each element
//   gets a fetch/compare/write step against the registered-read list
//   memories and, after all merge steps, one read of the merge buffer.
//   Results come out one beat per cycle on out_valid once every element has
//   been merged, with out_last on the final beat. The last beat shows in the
//   cycle busy drops, so the next command can be taken then.
//   A run with both lists empty gives no beat and does not raise busy.
//   After every run the list counts and the overflow flag are cleared.
//   The receiver cannot stall; each beat is valid for exactly one cycle.
//   Reset (synchronous, active low) empties both lists and clears the flag.
// ----------------------------------------------------------------------------
module sorted_list_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [sml_pkg::OP_W-1:0]          in_op,
  input  logic signed [sml_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  output logic signed [sml_pkg::DATA_W-1:0] out_merged_value,
  output logic                              out_last,
  output logic                              out_overflow
);

  sml_pkg::cmd_t    cmd;
  sml_pkg::status_t status;

  sml_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_op  (in_op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  sml_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_value),
    .status           (status),
    .out_valid        (out_valid),
    .out_merged_value (out_merged_value),
    .out_last         (out_last),
    .out_overflow     (out_overflow)
  );

endmodule

>>> rtl/sml_checker.sv
// ----------------------------------------------------------------------------
// sml_checker
// Port-level checks for sorted_list_merge, bound to the top level.
// ----------------------------------------------------------------------------
module sml_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [sml_pkg::OP_W-1:0]          in_op,
  input logic                              out_valid,
  input logic                              out_last,
  input logic                              out_overflow
);

  // reset leaves the block idle with no beat pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

  // loads never raise busy
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == sml_pkg::OP_LOAD_FIRST ||
                        in_op == sml_pkg::OP_LOAD_SECOND)) |=> !busy)
    else $error("load held the block busy");

  // beats of one run are back to back
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a run");

  // overflow is constant across a run
  a_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> (out_overflow == $past(out_overflow)))
    else $error("overflow changed within a run");

  // a new run cannot produce a beat right after the last one
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("beat directly after last");

endmodule

bind sorted_list_merge sml_checker u_sml_checker (.*);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_list_merge. Load and run commands go out
// through a command queue with random sender gaps. A local model tracks both
// lists, the counts and the drop flag, and builds the expected merged beats
// that the monitor compares field by field as each beat shows on the output.
// ----------------------------------------------------------------------------
module tb_top;
  import sml_pkg::*;

  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 3 * BUF_DEPTH + 8;
  localparam int ITEM_TARGET = 430;
  localparam int MAX_REPORTS = 60;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t word_q_t[$];

  typedef struct {
    logic [OP_W-1:0] op;
    word_t           value;
  } cmd_item_t;

  typedef struct {
    word_t value;
    logic  last;
    logic  overflow;
  } merge_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [OP_W-1:0] in_op = OP_LOAD_FIRST;
  word_t       in_value = '0;
  logic        out_valid;
  word_t       out_merged_value;
  logic        out_last;
  logic        out_overflow;

  sorted_list_merge i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_merged_value (out_merged_value),
    .out_last         (out_last),
    .out_overflow     (out_overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  word_t first_list [LIST_DEPTH];
  word_t second_list [LIST_DEPTH];
  int    first_count = 0;
  int    second_count = 0;
  bit    drop_seen = 1'b0;

  cmd_item_t   pending_cmds[$];
  merge_beat_t expected_beats[$];
  cmd_item_t   next_cmd;
  merge_beat_t got_beat;

  int cmds_sent = 0;
  int cmds_taken = 0;
  int stim_items = 0;
  int idle_pct = 0;
  int cycle_count = 0;
  int mismatches = 0;

  task report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS)
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Back-to-front fill: larger tail takes the highest open slot, second list
  // wins ties there, so the first list's element lands first in the output.
  task automatic apply_command(input logic [OP_W-1:0] op, input word_t value);
    word_t       merged [BUF_DEPTH];
    int          left_a;
    int          left_b;
    int          total;
    merge_beat_t beat;
    case (op)
      OP_LOAD_FIRST: begin
        if (first_count >= LIST_DEPTH) begin
          drop_seen = 1'b1;
        end else begin
          first_list[first_count] = value;
          first_count++;
        end
      end
      OP_LOAD_SECOND: begin
        if (second_count >= LIST_DEPTH) begin
          drop_seen = 1'b1;
        end else begin
          second_list[second_count] = value;
          second_count++;
        end
      end
      OP_RUN: begin
        left_a = first_count;
        left_b = second_count;
        total = left_a + left_b;
        for (int slot = total - 1; slot >= 0; slot--) begin
          if (left_a == 0) begin
            merged[slot] = second_list[left_b - 1];
            left_b--;
          end else if (left_b == 0) begin
            merged[slot] = first_list[left_a - 1];
            left_a--;
          end else if (first_list[left_a - 1] <= second_list[left_b - 1]) begin
            merged[slot] = second_list[left_b - 1];
            left_b--;
          end else begin
            merged[slot] = first_list[left_a - 1];
            left_a--;
          end
        end
        for (int k = 0; k < total; k++) begin
          beat.value = merged[k];
          beat.last = (k == total - 1);
          beat.overflow = drop_seen;
          expected_beats.push_back(beat);
        end
        first_count = 0;
        second_count = 0;
        drop_seen = 1'b0;
      end
      default: ;
    endcase
  endtask

  // driver: a new command goes out once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (cmds_taken == cmds_sent) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_cmd = pending_cmds.pop_front();
        in_op <= next_cmd.op;
        in_value <= next_cmd.value;
        start <= 1'b1;
        cmds_sent++;
      end else begin
        // junk on the idle bus must be ignored
        in_op <= OP_W'($urandom_range(3));
        in_value <= $urandom;
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat value %0d", out_merged_value));
        end else begin
          got_beat = expected_beats.pop_front();
          if (out_merged_value !== got_beat.value)
            report_mismatch($sformatf("merged_value %0d, expected %0d",
                                      out_merged_value, got_beat.value));
          if (out_last !== got_beat.last)
            report_mismatch($sformatf("last %b, expected %b", out_last, got_beat.last));
          if (out_overflow !== got_beat.overflow)
            report_mismatch($sformatf("overflow %b, expected %b",
                                      out_overflow, got_beat.overflow));
        end
      end
      if (start && !busy) begin
        apply_command(in_op, in_value);
        cmds_taken++;
      end
    end
  end

  task automatic push_cmd(input logic [OP_W-1:0] op, input word_t value);
    cmd_item_t item;
    item.op = op;
    item.value = value;
    pending_cmds.push_back(item);
    if (op != OP_IGNORED)
      stim_items++;
  endtask

  // mostly ascending list; a few are plain random (unsorted), a few stick to the corner values
  task automatic make_list(input int len, input word_t base, output word_q_t lst);
    word_t  corners [4];
    int     mode;
    int     pick;
    longint acc;
    corners = '{32'sh8000_0000, -32'sd1, 32'sd0, 32'sh7fff_ffff};
    lst = {};
    mode = $urandom_range(9);
    pick = 0;
    acc = base;
    repeat (len) begin
      if (mode == 0) begin
        lst.push_back(word_t'($urandom));
      end else if (mode == 1) begin
        pick = $urandom_range(3, pick);
        lst.push_back(corners[pick]);
      end else begin
        lst.push_back(word_t'(acc));
        case ($urandom_range(9))
          0, 1, 2, 3, 4: acc += $urandom_range(3);
          5, 6, 7, 8:    acc += $urandom_range(1000);
          default:       acc += $urandom;
        endcase
        if (acc > 64'sd2147483647)
          acc = 64'sd2147483647;
      end
    end
  endtask

  task automatic queue_merge_job(input int len_a, input int len_b);
    word_q_t la;
    word_q_t lb;
    word_t   base;
    base = $urandom;
    make_list(len_a, base, la);
    // shared start value makes cross-list ties likely
    make_list(len_b, $urandom_range(1) ? base : word_t'($urandom), lb);
    while (la.size() != 0 || lb.size() != 0) begin
      if ($urandom_range(19) == 0)
        push_cmd(OP_IGNORED, $urandom);
      if (lb.size() == 0 || (la.size() != 0 && $urandom_range(1)))
        push_cmd(OP_LOAD_FIRST, la.pop_front());
      else
        push_cmd(OP_LOAD_SECOND, lb.pop_front());
    end
    push_cmd(OP_RUN, $urandom);
    if ($urandom_range(15) == 0)
      push_cmd(OP_RUN, $urandom);
  endtask

  task wait_drained;
    while (pending_cmds.size() != 0 || cmds_taken != cmds_sent ||
           expected_beats.size() != 0)
      @(posedge clk);
  endtask

  int phase_idle [4] = '{0, 45, 8, 0};
  int job_idx = 0;
  int per_phase;
  int phase_goal;
  int len_a;
  int len_b;
  int sel;

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty run, ignored op, corner values with ties,
    // single-list runs, lists out of order
    push_cmd(OP_RUN, 32'sh7fff_ffff);
    push_cmd(OP_IGNORED, -32'sd1);
    push_cmd(OP_LOAD_FIRST, 32'sh8000_0000);
    push_cmd(OP_LOAD_SECOND, 32'sh8000_0000);
    push_cmd(OP_LOAD_FIRST, -32'sd1);
    push_cmd(OP_LOAD_SECOND, 32'sd0);
    push_cmd(OP_LOAD_FIRST, 32'sd0);
    push_cmd(OP_LOAD_SECOND, 32'sd0);
    push_cmd(OP_LOAD_FIRST, 32'sh7fff_ffff);
    push_cmd(OP_LOAD_SECOND, 32'sh7fff_ffff);
    push_cmd(OP_RUN, 32'sd0);
    push_cmd(OP_LOAD_FIRST, 32'sd5);
    push_cmd(OP_RUN, -32'sd1);
    push_cmd(OP_LOAD_SECOND, -32'sd5);
    push_cmd(OP_RUN, 32'sh5555_5555);
    push_cmd(OP_LOAD_FIRST, 32'sd10);
    push_cmd(OP_LOAD_FIRST, -32'sd3);
    push_cmd(OP_LOAD_SECOND, 32'sd7);
    push_cmd(OP_LOAD_SECOND, 32'sd7);
    push_cmd(OP_RUN, 32'shaaaa_aaaa);
    wait_drained();

    per_phase = (ITEM_TARGET - stim_items) / 4;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      phase_goal = stim_items + per_phase;
      while (stim_items < phase_goal) begin
        sel = $urandom_range(99);
        if (job_idx % 16 == 5) begin
          // overfill one side so loads get dropped
          len_a = LIST_DEPTH + 1 + $urandom_range(2);
          len_b = $urandom_range(LIST_DEPTH);
          if ($urandom_range(1)) begin
            len_b = len_a;
            len_a = $urandom_range(3);
          end
        end else if (sel < 82) begin
          len_a = $urandom_range(8);
          len_b = $urandom_range(8);
        end else if (sel < 95) begin
          len_a = $urandom_range(LIST_DEPTH);
          len_b = $urandom_range(LIST_DEPTH);
        end else begin
          len_a = LIST_DEPTH;
          len_b = LIST_DEPTH;
        end
        queue_merge_job(len_a, len_b);
        job_idx++;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_beats.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/sml_pkg.sv
rtl/sml_ram.sv
rtl/sml_ctrl.sv
rtl/sml_dp.sv
rtl/sorted_list_merge.sv
rtl/sml_checker.sv
tb/tb_top.sv
